// ===== rtl/c_integer_literal_decoder_assert.svh =====
// Assertion macros used by the top level of the integer literal decoder.
`ifndef C_INTEGER_LITERAL_DECODER_ASSERT_SVH
`define C_INTEGER_LITERAL_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cld assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cld assertion failed");

`endif

// ===== rtl/cld_pkg.sv =====
// Shared constants, types and character codes of the integer literal decoder.
package cld_pkg;

  // Accumulator width and token length limit.
  localparam int VALUE_WIDTH   = 64;
  localparam int MAX_TOKEN_LEN = 255;
  localparam int IDX_W         = $clog2(MAX_TOKEN_LEN + 1);

  // Fixed widths of the external fields.
  localparam int CHAR_W   = 8;
  localparam int OUT_W    = 64;
  localparam int SUFFIX_W = 8;
  localparam int CFG_IDX_W = 3;

  // Radix codes as reported on the result.
  typedef enum logic [1:0] {
    RadixDec = 2'd0,
    RadixOct = 2'd1,
    RadixHex = 2'd2,
    RadixBin = 2'd3
  } radix_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CfgHexPrefix  = 3'd0,
    CfgBinPrefix  = 3'd1,
    CfgOctPrefix  = 3'd2,
    CfgUnderscore = 3'd3,
    CfgTick       = 3'd4
  } cfg_idx_e;

  // Character codes.
  localparam logic [CHAR_W-1:0] ChZero  = 8'h30;
  localparam logic [CHAR_W-1:0] ChOne   = 8'h31;
  localparam logic [CHAR_W-1:0] ChNine  = 8'h39;
  localparam logic [CHAR_W-1:0] ChLowA  = 8'h61;
  localparam logic [CHAR_W-1:0] ChLowF  = 8'h66;
  localparam logic [CHAR_W-1:0] ChUpA   = 8'h41;
  localparam logic [CHAR_W-1:0] ChUpF   = 8'h46;
  localparam logic [CHAR_W-1:0] ChLowX  = 8'h78;
  localparam logic [CHAR_W-1:0] ChUpX   = 8'h58;
  localparam logic [CHAR_W-1:0] ChLowB  = 8'h62;
  localparam logic [CHAR_W-1:0] ChUpB   = 8'h42;
  localparam logic [CHAR_W-1:0] ChLowO  = 8'h6F;
  localparam logic [CHAR_W-1:0] ChUpO   = 8'h4F;
  localparam logic [CHAR_W-1:0] ChUnder = 8'h5F;
  localparam logic [CHAR_W-1:0] ChTick  = 8'h27;

  // Configuration bits as seen by the decoding logic.
  typedef struct packed {
    logic hex_en;
    logic bin_en;
    logic oct_en;
    logic under_en;
    logic tick_en;
  } cfg_t;

  // One finished result.
  typedef struct packed {
    logic [OUT_W-1:0]    value;
    logic                invalid;
    logic [SUFFIX_W-1:0] suffix_pos;
    radix_e              radix;
  } res_t;

endpackage

// ===== rtl/cld_cfg.sv =====
// Configuration registers of the integer literal decoder.
module cld_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cld_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                     cfg_data_i,
  output cld_pkg::cfg_t            cfg_o
);
  import cld_pkg::*;

  cfg_t cfg_q;

  // Single-bit registers, all enabled after reset; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgHexPrefix:  cfg_q.hex_en   <= cfg_data_i;
        CfgBinPrefix:  cfg_q.bin_en   <= cfg_data_i;
        CfgOctPrefix:  cfg_q.oct_en   <= cfg_data_i;
        CfgUnderscore: cfg_q.under_en <= cfg_data_i;
        CfgTick:       cfg_q.tick_en  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/cld_core.sv =====
// Token state and per-character decoding step of the integer literal decoder.
module cld_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cld_pkg::cfg_t              cfg_i,
  input  logic                       step_i,
  input  logic [cld_pkg::CHAR_W-1:0] char_i,
  input  logic                       last_i,
  output cld_pkg::res_t              res_o
);
  import cld_pkg::*;

  localparam int PW = VALUE_WIDTH + 4;

  typedef enum logic [2:0] {
    PhFirst,
    PhZero,
    PhPrefix,
    PhDigits,
    PhSuffix,
    PhBad
  } phase_e;

  phase_e                 phase_q, phase_d;
  radix_e                 radix_q, radix_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       suf_q, suf_d;
  logic                   bad_q, bad_d;

  logic                   is_digit;
  logic                   is_sep;
  logic [3:0]             dig_val;
  logic [4:0]             radix_val;
  radix_e                 eff_radix;
  logic [PW-1:0]          acc_ext;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          sum;
  logic                   ovf;
  logic [IDX_W-1:0]       pos_inc;
  logic                   bad_fin;

  // Digit and separator decode of the incoming character.
  always_comb begin
    is_digit = 1'b1;
    dig_val  = '0;
    if (char_i >= ChZero && char_i <= ChNine) begin
      dig_val = 4'(char_i - ChZero);
    end else if (char_i >= ChLowA && char_i <= ChLowF) begin
      dig_val = 4'(char_i - ChLowA + 8'd10);
    end else if (char_i >= ChUpA && char_i <= ChUpF) begin
      dig_val = 4'(char_i - ChUpA + 8'd10);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign is_sep = (char_i == ChUnder && cfg_i.under_en) ||
                  (char_i == ChTick && cfg_i.tick_en);

  // Radix in force for this character: the first character is decimal and the leading-zero phase forces octal.
  always_comb begin
    unique case (phase_q)
      PhFirst: eff_radix = RadixDec;
      PhZero:  eff_radix = RadixOct;
      default: eff_radix = radix_q;
    endcase
  end

  // Multiply-add by the radix as shifts and at most two adds, with a carry-out check.
  assign acc_ext = PW'(acc_q);
  always_comb begin
    unique case (eff_radix)
      RadixDec: begin
        radix_val = 5'd10;
        prod      = (acc_ext << 3) + (acc_ext << 1);
      end
      RadixOct: begin
        radix_val = 5'd8;
        prod      = acc_ext << 3;
      end
      RadixHex: begin
        radix_val = 5'd16;
        prod      = acc_ext << 4;
      end
      RadixBin: begin
        radix_val = 5'd2;
        prod      = acc_ext << 1;
      end
      default: begin
        radix_val = 5'd10;
        prod      = acc_ext;
      end
    endcase
  end

  assign sum     = prod + PW'(dig_val);
  assign ovf     = |sum[PW-1:VALUE_WIDTH];
  assign pos_inc = idx_q + IDX_W'(1);

  // Next token state for one character.
  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    suf_d   = suf_q;
    bad_d   = bad_q;

    if (idx_q >= IDX_W'(MAX_TOKEN_LEN)) begin
      bad_d   = 1'b1;
      phase_d = PhBad;
    end else begin
      idx_d = pos_inc;
      unique case (phase_q)
        PhFirst, PhZero, PhPrefix, PhDigits: begin
          if (phase_q == PhFirst) begin
            radix_d = RadixDec;
          end else if (phase_q == PhZero) begin
            radix_d = RadixOct;
          end

          priority if (phase_q == PhFirst && char_i == ChZero) begin
            suf_d   = IDX_W'(1);
            phase_d = PhZero;
          end else if (phase_q == PhFirst &&
                       !(char_i >= ChOne && char_i <= ChNine)) begin
            bad_d   = 1'b1;
            phase_d = PhBad;
          end else if (phase_q == PhZero &&
                       (char_i == ChLowX || char_i == ChUpX) && cfg_i.hex_en) begin
            radix_d = RadixHex;
            phase_d = PhPrefix;
          end else if (phase_q == PhZero &&
                       (char_i == ChLowB || char_i == ChUpB) && cfg_i.bin_en) begin
            radix_d = RadixBin;
            phase_d = PhPrefix;
          end else if (phase_q == PhZero &&
                       (char_i == ChLowO || char_i == ChUpO) && cfg_i.oct_en) begin
            radix_d = RadixOct;
            phase_d = PhPrefix;
          end else if (!is_digit && is_sep) begin
            phase_d = PhDigits;
          end else if (!is_digit || 5'(dig_val) >= radix_val) begin
            phase_d = PhSuffix;
          end else if (ovf) begin
            bad_d   = 1'b1;
            phase_d = PhBad;
          end else begin
            acc_d   = sum[VALUE_WIDTH-1:0];
            suf_d   = pos_inc;
            phase_d = PhDigits;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A prefix that ends the token spoils the literal.
  assign bad_fin = bad_d || (phase_d == PhPrefix);

  // Result built from the state after the last character.
  always_comb begin
    if (bad_fin) begin
      res_o.value      = '0;
      res_o.invalid    = 1'b1;
      res_o.suffix_pos = SUFFIX_W'(idx_d);
      res_o.radix      = RadixDec;
    end else begin
      res_o.value      = OUT_W'(acc_d);
      res_o.invalid    = 1'b0;
      res_o.suffix_pos = SUFFIX_W'(suf_d);
      res_o.radix      = radix_d;
    end
  end

  // State registers; the last character of a token returns them to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      radix_q <= RadixDec;
      acc_q   <= '0;
      idx_q   <= '0;
      suf_q   <= '0;
      bad_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PhFirst;
        radix_q <= RadixDec;
        acc_q   <= '0;
        idx_q   <= '0;
        suf_q   <= '0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        radix_q <= radix_d;
        acc_q   <= acc_d;
        idx_q   <= idx_d;
        suf_q   <= suf_d;
        bad_q   <= bad_d;
      end
    end
  end

endmodule

// ===== rtl/c_integer_literal_decoder.sv =====
// Top level of the streaming C integer literal decoder.
// Takes one character of a numeric token per item and, on the item marked
// last_char, returns one result: the value, an invalid flag, the index where
// the suffix starts and the radix used. Items pass through an input register,
// one decoding step (a multiply-add by the radix done as shifts and at most
// two 68-bit adds with a carry-out check) and a result register, so the block
// accepts one character every cycle unless a last character is stalled. A last
// character waits in the input register, passes the decoding step and has its
// result written to the result register, which presents it. Characters keep
// flowing while a result waits; only a last character that finds the result
// register still full waits until that result is taken.
`include "c_integer_literal_decoder_assert.svh"
module c_integer_literal_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cld_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic                               cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [cld_pkg::CHAR_W-1:0]         character_i,
  input  logic                               last_char_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cld_pkg::OUT_W-1:0]          value_o,
  output logic                               invalid_o,
  output logic [cld_pkg::SUFFIX_W-1:0]       suffix_position_o,
  output logic [1:0]                         radix_used_o
);
  import cld_pkg::*;

  cfg_t              cfg;
  res_t              res;
  res_t              res_q;
  logic              in_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              out_valid_q;
  logic              step_fire;

  cld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The held item steps unless it ends a token and the result slot is blocked.
  assign step_fire  = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= character_i;
      last_q <= last_char_i;
    end
  end

  cld_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step_fire),
    .char_i (char_q),
    .last_i (last_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && last_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign value_o           = res_q.value;
  assign invalid_o         = res_q.invalid;
  assign suffix_position_o = res_q.suffix_pos;
  assign radix_used_o      = res_q.radix;

  // An invalid literal always reports zero in decimal.
  `CLD_ASSERT_NOW(a_invalid_clean, out_valid_o && invalid_o, value_o == '0 && radix_used_o == RadixDec)
  // Finishing a token always fills the result register.
  `CLD_ASSERT_NEXT(a_last_fills_out, step_fire && last_q, out_valid_q)
  // A held item that cannot step blocks new input.
  `CLD_ASSERT_NOW(a_stall_blocks_in, in_valid_q && !step_fire, !in_ready_o)

endmodule

// ===== verif/c_integer_literal_decoder_tb.sv =====
// Self-checking testbench for the streaming C integer literal decoder.
`timescale 1ns / 100ps

module c_integer_literal_decoder_tb;
  import cld_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int PrintCap   = 60;

  // One character of a token as offered to the block.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } char_item_t;

  typedef logic [CHAR_W-1:0] token_t[$];

  // Decoding phases of the prediction.
  typedef enum logic [2:0] {
    PhFirst,
    PhZero,
    PhPrefix,
    PhDigits,
    PhSuffix,
    PhBad
  } lit_phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic                 cfg_data_i = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [CHAR_W-1:0]    character_i = '0;
  logic                 last_char_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [OUT_W-1:0]     value_o;
  logic                 invalid_o;
  logic [SUFFIX_W-1:0]  suffix_position_o;
  logic [1:0]           radix_used_o;

  c_integer_literal_decoder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .character_i       (character_i),
    .last_char_i       (last_char_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .value_o           (value_o),
    .invalid_o         (invalid_o),
    .suffix_position_o (suffix_position_o),
    .radix_used_o      (radix_used_o)
  );

  // Characters waiting to be offered, and literals waiting to come out.
  char_item_t pending_chars[$];
  res_t       expected_literals[$];
  int         error_count = 0;
  int         cycle_count = 0;

  // Copy of the settings and of the token being decoded.
  cfg_t             cfg_model;
  lit_phase_e       lit_phase;
  radix_e           lit_radix;
  logic [OUT_W-1:0] lit_acc;
  int               lit_len;
  int               lit_sfx;
  bit               lit_bad;

  // Driver and receiver bookkeeping.
  logic       in_taken = 1'b0;
  char_item_t drv_item;
  int         burst_left = 0;
  int         gap_left = 0;
  int         rx_cycles = 0;
  int         rx_mode = 0;
  int         hold_left = 0;
  int         next_hold_at = 300;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    if (error_count < PrintCap) $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void clear_literal();
    lit_phase = PhFirst;
    lit_radix = RadixDec;
    lit_acc   = '0;
    lit_len   = 0;
    lit_sfx   = 0;
    lit_bad   = 1'b0;
  endfunction

  function automatic void mark_bad();
    lit_bad   = 1'b1;
    lit_phase = PhBad;
  endfunction

  // One pass of the digit loop: accumulate, skip a separator, start the suffix or flag an overflow.
  function automatic void take_digit(input logic [CHAR_W-1:0] c, input int pos);
    logic [OUT_W-1:0] d;
    logic [OUT_W-1:0] r;
    logic [OUT_W-1:0] maxv;
    maxv = {VALUE_WIDTH{1'b1}};
    if (c >= ChZero && c <= ChNine) begin
      d = OUT_W'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowF) begin
      d = OUT_W'(c - ChLowA) + OUT_W'(10);
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = OUT_W'(c - ChUpA) + OUT_W'(10);
    end else begin
      if ((c == ChUnder && cfg_model.under_en) || (c == ChTick && cfg_model.tick_en)) begin
        lit_phase = PhDigits;
      end else begin
        lit_phase = PhSuffix;
      end
      return;
    end
    case (lit_radix)
      RadixDec: r = OUT_W'(10);
      RadixOct: r = OUT_W'(8);
      RadixHex: r = OUT_W'(16);
      default:  r = OUT_W'(2);
    endcase
    if (d >= r) begin
      lit_phase = PhSuffix;
      return;
    end
    if (lit_acc > (maxv - d) / r) begin
      mark_bad();
      return;
    end
    lit_acc   = lit_acc * r + d;
    lit_sfx   = pos + 1;
    lit_phase = PhDigits;
  endfunction

  // Advances the prediction by one accepted character; a last character
  // queues the expected literal.
  function automatic void decode_char(input logic [CHAR_W-1:0] c, input logic is_last);
    int   pos;
    res_t lit;
    pos = lit_len;
    if (pos >= MAX_TOKEN_LEN) begin
      mark_bad();
    end else begin
      lit_len = pos + 1;
      case (lit_phase)
        PhFirst: begin
          if (c == ChZero) begin
            lit_sfx   = 1;
            lit_phase = PhZero;
          end else if (c >= ChOne && c <= ChNine) begin
            lit_radix = RadixDec;
            take_digit(c, pos);
          end else begin
            mark_bad();
          end
        end
        PhZero: begin
          lit_radix = RadixOct;
          if ((c == ChLowX || c == ChUpX) && cfg_model.hex_en) begin
            lit_radix = RadixHex;
            lit_phase = PhPrefix;
          end else if ((c == ChLowB || c == ChUpB) && cfg_model.bin_en) begin
            lit_radix = RadixBin;
            lit_phase = PhPrefix;
          end else if ((c == ChLowO || c == ChUpO) && cfg_model.oct_en) begin
            lit_phase = PhPrefix;
          end else begin
            take_digit(c, pos);
          end
        end
        PhPrefix, PhDigits: take_digit(c, pos);
        default: ;
      endcase
    end
    if (is_last) begin
      // A prefix with nothing after it makes the literal invalid.
      if (lit_phase == PhPrefix) mark_bad();
      if (lit_bad) begin
        lit.value      = '0;
        lit.invalid    = 1'b1;
        lit.suffix_pos = SUFFIX_W'(lit_len);
        lit.radix      = RadixDec;
      end else begin
        lit.value      = lit_acc;
        lit.invalid    = 1'b0;
        lit.suffix_pos = SUFFIX_W'(lit_sfx);
        lit.radix      = lit_radix;
      end
      expected_literals.push_back(lit);
      clear_literal();
    end
  endfunction

  // Compares one result with the oldest expected literal.
  task automatic check_result();
    res_t want;
    if (expected_literals.size() == 0) begin
      report_error("result arrived with no literal pending");
      return;
    end
    want = expected_literals.pop_front();
    if (value_o !== want.value)
      report_error($sformatf("value %h, expected %h", value_o, want.value));
    if (invalid_o !== want.invalid)
      report_error($sformatf("invalid %b, expected %b", invalid_o, want.invalid));
    if (suffix_position_o !== want.suffix_pos)
      report_error($sformatf("suffix_position %0d, expected %0d",
                             suffix_position_o, want.suffix_pos));
    if (radix_used_o !== want.radix)
      report_error($sformatf("radix_used %0d, expected %0d", radix_used_o, want.radix));
  endtask

  // Sampling at the rising edge: results first, then accepted characters.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    if (rst_ni && in_valid_i && in_ready_o) decode_char(character_i, last_char_i);
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // Sender: bursts of items of random length with random gaps between them.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        drv_item = pending_chars.pop_front();
        in_valid_i  <= 1'b1;
        character_i <= drv_item.ch;
        last_char_i <= drv_item.is_last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: a stall pattern that changes mode now and then, plus long
  // hold-offs while the sender keeps offering, so that the block backs up.
  always @(negedge clk_i) begin
    rx_cycles++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_cycles >= next_hold_at && out_valid_o && in_valid_i) begin
      hold_left    = $urandom_range(300, 500);
      next_hold_at = rx_cycles + 1500;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_cycles % 64 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Writes one register while the block is idle and mirrors it in the model.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgHexPrefix:  cfg_model.hex_en   = v;
      CfgBinPrefix:  cfg_model.bin_en   = v;
      CfgOctPrefix:  cfg_model.oct_en   = v;
      CfgUnderscore: cfg_model.under_en = v;
      CfgTick:       cfg_model.tick_en  = v;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(CfgHexPrefix, s.hex_en);
    write_reg(CfgBinPrefix, s.bin_en);
    write_reg(CfgOctPrefix, s.oct_en);
    write_reg(CfgUnderscore, s.under_en);
    write_reg(CfgTick, s.tick_en);
  endtask

  // Waits until every character is taken and every literal has come out,
  // then lets the pipeline settle.
  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_valid_i || expected_literals.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic void queue_token(input token_t tok);
    char_item_t item;
    for (int i = 0; i < tok.size(); i++) begin
      item.ch      = tok[i];
      item.is_last = (i == tok.size() - 1);
      pending_chars.push_back(item);
    end
  endfunction

  function automatic void queue_text(input string s);
    token_t tok;
    for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    queue_token(tok);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Builds one random token, mostly well-formed literals of each radix with
  // separators and suffixes, some overflows, some noise and rarely an overlong token; returns its length.
  function automatic int queue_random_literal();
    token_t tok;
    string  digits;
    int     kind;
    int     n;
    kind   = $urandom_range(0, 99);
    digits = "0123456789";
    n      = 0;
    if (kind < 22) begin
      tok.push_back(pick_char("123456789"));
      n = $urandom_range(0, 12);
    end else if (kind < 34) begin
      tok.push_back(ChZero);
      if ($urandom_range(0, 3) != 0) digits = "01234567";
      n = $urandom_range(0, 10);
    end else if (kind < 52) begin
      tok.push_back(ChZero);
      tok.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
      digits = "0123456789abcdefABCDEF";
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 8);
    end else if (kind < 64) begin
      tok.push_back(ChZero);
      tok.push_back($urandom_range(0, 1) ? ChLowB : ChUpB);
      digits = "01";
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 16);
    end else if (kind < 72) begin
      tok.push_back(ChZero);
      tok.push_back($urandom_range(0, 1) ? ChLowO : ChUpO);
      digits = "01234567";
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 23) : $urandom_range(0, 8);
    end else if (kind < 80) begin
      tok.push_back(ChZero);
    end else if (kind < 86) begin
      tok.push_back(pick_char("123456789"));
      n = $urandom_range(18, 21);
    end else if (kind < 99) begin
      repeat ($urandom_range(1, 6)) tok.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      // Overlong token of zeros and separators.
      tok.push_back(ChZero);
      digits = "00_'";
      n = $urandom_range(250, 262);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) tok.push_back(pick_char("_'"));
      tok.push_back(pick_char(digits));
    end
    if (kind < 86 && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) tok.push_back(pick_char("uUlLzg.+"));
    queue_token(tok);
    return tok.size();
  endfunction

  task automatic queue_random_chars(input int target);
    int n;
    n = 0;
    while (n < target) n += queue_random_literal();
  endtask

  // Builds a token of a leading zero followed by zeros, of the given length.
  task automatic queue_zeros(input int len);
    token_t tok;
    repeat (len) tok.push_back(ChZero);
    queue_token(tok);
  endtask

  // Test sequence.
  initial begin
    cfg_t s;
    cfg_model = '1;
    clear_literal();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed tokens with every option enabled, as after reset.
    queue_text("0");
    queue_text("7");
    queue_text("9");
    queue_text("017");
    queue_text("089");
    queue_text("0x");
    queue_text("0X1f");
    queue_text("0b101");
    queue_text("0B2");
    queue_text("0o17");
    queue_text("0O8");
    queue_text("0x_1");
    queue_text("1_000");
    queue_text("1'000'000");
    queue_text("1__2'_3");
    queue_text("123ull");
    queue_text("a1");
    queue_text("\377a");
    queue_text("0xffffffffffffffff");
    queue_text("0x1_0000_0000_0000_0000");
    queue_text("18446744073709551615");
    queue_text("18446744073709551616");
    queue_zeros(MAX_TOKEN_LEN);
    queue_zeros(MAX_TOKEN_LEN + 5);
    wait_idle();

    queue_random_chars(100);
    wait_idle();

    // Everything disabled; writes to unused indexes must change nothing.
    apply_settings('0);
    for (int i = int'(CfgTick) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), 1'b1);
    queue_text("0x1");
    queue_text("0X");
    queue_text("0b1");
    queue_text("0B");
    queue_text("0o1");
    queue_text("1_0");
    queue_text("1'0");
    queue_random_chars(35);
    wait_idle();

    // Mixed settings.
    repeat (4) begin
      s = cfg_t'(5'($urandom_range(0, 31)));
      apply_settings(s);
      queue_random_chars(25);
      wait_idle();
    end

    apply_settings('1);
    queue_random_chars(20);
    wait_idle();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
